// File: src/altitude_rate_ema_estimator_top_macros.svh
// Assertion macros for the checker of the altitude rate block.
`ifndef ALTITUDE_RATE_EMA_ESTIMATOR_TOP_MACROS_SVH
`define ALTITUDE_RATE_EMA_ESTIMATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/are_pkg.sv
`default_nettype none

package are_pkg;

    // Default number of fraction bits of the stored velocity.
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register width and reset value (about 0.1 in Q1.16).
    localparam int          ALPHA_W     = 17;
    localparam logic [16:0] ALPHA_RESET = 17'd6554;
    localparam logic [16:0] ALPHA_ONE   = 17'd65536;

    // Microseconds per second, one operand of the shared multiplier.
    localparam int          CONST_W  = 20;
    localparam logic [19:0] US_PER_S = 20'd1000000;

    // One input item.
    typedef struct packed {
        logic signed [31:0] altitude_cm;
        logic        [31:0] time_us;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] velocity_cm_s;
        logic               zero_interval;
        logic               saturated;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CHK,
        S_DIV,
        S_RATE,
        S_DIFF,
        S_MHI,
        S_MLO,
        S_UPD,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// File: src/altitude_rate_ema_estimator_top.sv
// Channel    | Signals                                      | Moves
// -----------+----------------------------------------------+---------------------------
// input      | i_in_valid, o_in_ready, i_in_item            | altitude and timestamp
// output     | o_out_valid, i_out_ready, o_out_item         | velocity and flags
// config     | i_cfg_we, i_cfg_data                         | smoothing factor, Q1.16
//
// An item with a nonzero interval passes S_MUL, S_CHK, the one-bit-per-cycle restoring
// divider that runs 32 + FRAC_BITS steps, then S_RATE, S_DIFF, S_MHI, S_MLO and S_UPD
// to S_OUT, which loads the result. A rate that overflows skips the divider; a zero interval
// goes straight to S_OUT. One item is in work at a time; the input is ready again
// once the result is in the output register, even while that result waits to be taken.
// Reset is synchronous and active low; it clears the state and the output valid flag and
// returns the factor to its reset value.
`default_nettype none

module altitude_rate_ema_estimator_top #(
    parameter int FRAC_BITS = are_pkg::FRAC_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  are_pkg::t_in_item      i_in_item,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output are_pkg::t_out_item     o_out_item,
    input  wire                    i_cfg_we,
    input  wire [are_pkg::ALPHA_W-1:0] i_cfg_data
);

    // Velocity and rate width, divider steps and shared multiplier widths.
    localparam int W      = 32 + FRAC_BITS;
    localparam int CNT_W  = $clog2(W);
    localparam int MUL_W  = (W - 16 > 33) ? (W - 16) : 33;
    localparam int PROD_W = MUL_W + are_pkg::CONST_W;

    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};

    are_pkg::t_state r_state, n_state;

    logic [are_pkg::ALPHA_W-1:0] r_alpha;
    logic [31:0]    r_last_time;
    logic [31:0]    r_last_alt;
    logic [W-1:0]   r_vel;

    logic [31:0]    r_dt;
    logic [32:0]    r_adiff;
    logic           r_neg;
    logic [51:0]    r_num;
    logic [31:0]    r_rem;
    logic [31:0]    r_nshift;
    logic [W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic           r_ovf;
    logic [W-1:0]   r_rate;
    logic [W-1:0]   r_ad;
    logic           r_dneg;
    logic [W-1:0]   r_step;
    logic           r_zero;
    logic           r_sat;
    logic           r_out_valid;
    are_pkg::t_out_item r_out;

    logic [31:0]    dt_in;
    logic [32:0]    diff_in;
    logic [32:0]    adiff_in;
    logic [are_pkg::ALPHA_W-1:0] alpha_eff;
    logic [MUL_W-1:0] mul_a;
    logic [are_pkg::CONST_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic           ovf_chk;
    logic [32:0]    trial;
    logic           qbit;
    logic [W-1:0]   mag;
    logic           mag_sat;
    logic [W:0]     d_full;
    logic [W-1:0]   bias;
    logic [W-1:0]   vel_biased;
    logic           in_acc;
    logic           out_load;
    logic           div_last;

    // Interval and altitude change of the item on the input.
    assign dt_in    = i_in_item.time_us - r_last_time;
    assign diff_in  = {i_in_item.altitude_cm[31], i_in_item.altitude_cm}
                    - {r_last_alt[31], r_last_alt};
    assign adiff_in = diff_in[32] ? (33'd0 - diff_in) : diff_in;

    // A factor above 1.0 acts as 1.0.
    assign alpha_eff = (r_alpha > are_pkg::ALPHA_ONE) ? are_pkg::ALPHA_ONE : r_alpha;

    // Shared multiplier: scale by one million, then the two halves of the blend step.
    always_comb begin
        case (r_state)
            are_pkg::S_MUL: begin
                mul_a = MUL_W'(r_adiff);
                mul_b = are_pkg::US_PER_S;
            end
            are_pkg::S_MHI: begin
                mul_a = MUL_W'(r_ad >> 16);
                mul_b = {{(are_pkg::CONST_W-are_pkg::ALPHA_W){1'b0}}, alpha_eff};
            end
            default: begin
                mul_a = MUL_W'(r_ad[15:0]);
                mul_b = {{(are_pkg::CONST_W-are_pkg::ALPHA_W){1'b0}}, alpha_eff};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Quotient overflow test: the integer quotient reaches 2^32.
    assign ovf_chk = {12'd0, r_num[51:32]} >= r_dt;

    // One restoring division step.
    assign trial = {r_rem, r_nshift[31]};
    assign qbit  = trial >= {1'b0, r_dt};
    assign div_last = r_cnt == CNT_W'(W - 1);

    // Rate magnitude, clipped to the signed range of the velocity.
    always_comb begin
        mag     = r_quo;
        mag_sat = 1'b0;
        if (r_ovf) begin
            mag     = r_neg ? LIM_NEG : LIM_POS;
            mag_sat = 1'b1;
        end else if (r_neg && r_quo[W-1] && (|r_quo[W-2:0])) begin
            mag     = LIM_NEG;
            mag_sat = 1'b1;
        end else if (!r_neg && r_quo[W-1]) begin
            mag     = LIM_POS;
            mag_sat = 1'b1;
        end
    end

    // Difference between the new rate and the stored velocity.
    assign d_full = {r_rate[W-1], r_rate} - {r_vel[W-1], r_vel};

    // Integer part of the velocity, rounded toward zero.
    assign bias       = {{(W-FRAC_BITS){1'b0}}, {FRAC_BITS{r_vel[W-1]}}};
    assign vel_biased = r_vel + bias;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            are_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (dt_in == 32'd0) ? are_pkg::S_OUT : are_pkg::S_MUL;
                end
            end
            are_pkg::S_MUL:  n_state = are_pkg::S_CHK;
            are_pkg::S_CHK:  n_state = ovf_chk ? are_pkg::S_RATE : are_pkg::S_DIV;
            are_pkg::S_DIV: begin
                if (div_last) begin
                    n_state = are_pkg::S_RATE;
                end
            end
            are_pkg::S_RATE: n_state = are_pkg::S_DIFF;
            are_pkg::S_DIFF: n_state = are_pkg::S_MHI;
            are_pkg::S_MHI:  n_state = are_pkg::S_MLO;
            are_pkg::S_MLO:  n_state = are_pkg::S_UPD;
            are_pkg::S_UPD:  n_state = are_pkg::S_OUT;
            are_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = are_pkg::S_IDLE;
                end
            end
            default: n_state = are_pkg::S_IDLE;
        endcase
    end

    // Handshake controls.
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            are_pkg::S_IDLE: o_in_ready = 1'b1;
            are_pkg::S_OUT:  out_load   = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                out_load   = 1'b0;
            end
        endcase
    end
    assign in_acc = i_in_valid && o_in_ready;

    // State, configuration, the last sample, the velocity and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= are_pkg::S_IDLE;
            r_alpha     <= are_pkg::ALPHA_RESET;
            r_last_time <= 32'd0;
            r_last_alt  <= 32'd0;
            r_vel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_alpha <= i_cfg_data;
            end
            if (in_acc) begin
                r_last_time <= i_in_item.time_us;
                r_last_alt  <= i_in_item.altitude_cm;
            end
            if (r_state == are_pkg::S_UPD) begin
                r_vel <= r_dneg ? (r_vel - r_step) : (r_vel + r_step);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            are_pkg::S_IDLE: begin
                r_dt    <= dt_in;
                r_adiff <= adiff_in;
                r_neg   <= diff_in[32];
                r_zero  <= dt_in == 32'd0;
                r_sat   <= 1'b0;
            end
            are_pkg::S_MUL: begin
                r_num <= mul_p[51:0];
            end
            are_pkg::S_CHK: begin
                r_ovf    <= ovf_chk;
                r_rem    <= {12'd0, r_num[51:32]};
                r_nshift <= r_num[31:0];
                r_quo    <= '0;
                r_cnt    <= '0;
            end
            are_pkg::S_DIV: begin
                r_rem    <= qbit ? 32'(trial - {1'b0, r_dt}) : trial[31:0];
                r_nshift <= {r_nshift[30:0], 1'b0};
                r_quo    <= {r_quo[W-2:0], qbit};
                r_cnt    <= r_cnt + CNT_W'(1);
            end
            are_pkg::S_RATE: begin
                r_rate <= r_neg ? (W'(0) - mag) : mag;
                r_sat  <= mag_sat;
            end
            are_pkg::S_DIFF: begin
                r_dneg <= d_full[W];
                r_ad   <= d_full[W] ? W'((W+1)'(0) - d_full) : d_full[W-1:0];
            end
            are_pkg::S_MHI: begin
                r_step <= mul_p[W-1:0];
            end
            are_pkg::S_MLO: begin
                r_step <= r_step + W'(mul_p[32:16]);
            end
            are_pkg::S_OUT: begin
                if (out_load) begin
                    r_out.velocity_cm_s <= vel_biased[W-1:FRAC_BITS];
                    r_out.zero_interval <= r_zero;
                    r_out.saturated     <= r_sat;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: src/are_checker.sv
`default_nettype none
`include "altitude_rate_ema_estimator_top_macros.svh"

module are_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                o_in_ready,
    input wire                o_out_valid,
    input wire                i_out_ready,
    input are_pkg::t_out_item o_out_item
);

    // The block is busy in the cycle after it takes an item.
    `ARE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after an accepted item")

    // A held interval never reports a clipped rate.
    `ARE_ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, o_out_valid, !(o_out_item.zero_interval && o_out_item.saturated), "zero interval and saturated both set")

    // A stalled result stays offered.
    `ARE_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // A stalled result keeps its value.
    `ARE_ASSERT_NEXT(a_out_item_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item), "result changed while stalled")

endmodule

bind altitude_rate_ema_estimator_top are_checker u_are_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// File: tb/altitude_rate_ema_estimator_checker.sv
`default_nettype none

module altitude_rate_ema_estimator_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_in_ready,
    input  are_pkg::t_in_item           i_in_item,
    input  wire                         i_out_valid,
    input  wire                         i_out_ready,
    input  are_pkg::t_out_item          i_out_item,
    input  wire                         i_cfg_we,
    input  wire [are_pkg::ALPHA_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_zero_count,
    output int                          o_clip_count
);

    localparam int          FRAC         = are_pkg::FRAC_BITS_DEF;
    localparam int          GAIN_FRAC    = 16;
    localparam logic [63:0] GAIN_MASK    = 64'hFFFF;
    localparam logic [63:0] QUOT_LIMIT   = 64'h1_0000_0000;
    localparam logic [63:0] RATE_LIM_NEG = 64'h8000_0000 << FRAC;
    localparam logic [63:0] RATE_LIM_POS = RATE_LIM_NEG - 64'd1;
    localparam int          REPORT_MAX   = 10;

    // Shadow of the block's state and of its smoothing register.
    logic [are_pkg::ALPHA_W-1:0] alpha_q;
    logic [31:0]                 prev_time;
    longint                      prev_alt;
    longint                      vel_acc;

    // Velocities predicted for items accepted but not yet answered.
    are_pkg::t_out_item pending_velocities [$];
    are_pkg::t_out_item want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_zero_count = 0;
        o_clip_count = 0;
    end

    // Differences one sample against the last one, blends the rate into the
    // stored velocity and returns the result that the block must emit.
    function automatic are_pkg::t_out_item advance_velocity(input are_pkg::t_in_item it);
        logic [31:0]        dt;
        longint             alt;
        longint             diff;
        longint             rate;
        longint             lag;
        longint             vel;
        logic [63:0]        mag_in;
        logic [63:0]        num;
        logic [63:0]        quo;
        logic [63:0]        rem;
        logic [63:0]        mag;
        logic [63:0]        ad;
        logic [63:0]        step;
        logic [63:0]        gain;
        logic               neg;
        are_pkg::t_out_item res;
        alt       = {{32{it.altitude_cm[31]}}, it.altitude_cm};
        dt        = it.time_us - prev_time;
        diff      = alt - prev_alt;
        vel       = vel_acc;
        prev_time = it.time_us;
        prev_alt  = alt;
        res       = '0;
        if (dt == 32'd0) begin
            // Nothing to divide by: the velocity is held.
            res.zero_interval = 1'b1;
        end else begin
            // Rate magnitude, truncated to the fraction bits and clipped.
            neg    = (diff < 0);
            mag_in = neg ? -diff : diff;
            num    = mag_in * {44'd0, are_pkg::US_PER_S};
            quo    = num / {32'd0, dt};
            rem    = num % {32'd0, dt};
            if (quo >= QUOT_LIMIT) begin
                mag           = neg ? RATE_LIM_NEG : RATE_LIM_POS;
                res.saturated = 1'b1;
            end else begin
                mag = (quo << FRAC) + ((rem << FRAC) / {32'd0, dt});
                if (neg && mag > RATE_LIM_NEG) begin
                    mag           = RATE_LIM_NEG;
                    res.saturated = 1'b1;
                end
                if (!neg && mag > RATE_LIM_POS) begin
                    mag           = RATE_LIM_POS;
                    res.saturated = 1'b1;
                end
            end
            rate = neg ? -$signed(mag) : $signed(mag);

            // Smoothing step, truncated toward zero; factors above one act as one.
            gain = (alpha_q > are_pkg::ALPHA_ONE) ? {47'd0, are_pkg::ALPHA_ONE}
                                                   : {47'd0, alpha_q};
            lag  = rate - vel;
            ad   = (lag < 0) ? -lag : lag;
            step = (ad >> GAIN_FRAC) * gain + (((ad & GAIN_MASK) * gain) >> GAIN_FRAC);
            vel  = (lag < 0) ? vel - $signed(step) : vel + $signed(step);
            vel_acc = vel;
        end

        // Integer part of the velocity, rounded toward zero.
        if (vel < 0) begin
            mag = -vel;
            mag = mag >> FRAC;
            res.velocity_cm_s = -mag[31:0];
        end else begin
            mag = vel;
            mag = mag >> FRAC;
            res.velocity_cm_s = mag[31:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alpha_q   = are_pkg::ALPHA_RESET;
            prev_time = '0;
            prev_alt  = 0;
            vel_acc   = 0;
            pending_velocities.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                alpha_q = i_cfg_data;
            end

            // Results are matched first, so an item accepted at the same edge
            // can never answer for itself.
            if (i_out_valid && i_out_ready) begin
                if (pending_velocities.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX) begin
                        $display("Unexpected result: velocity %0d zero_interval %b saturated %b",
                                 i_out_item.velocity_cm_s, i_out_item.zero_interval,
                                 i_out_item.saturated);
                    end
                end else begin
                    want = pending_velocities.pop_front();
                    o_checked++;
                    if (i_out_item.velocity_cm_s !== want.velocity_cm_s ||
                        i_out_item.zero_interval !== want.zero_interval ||
                        i_out_item.saturated !== want.saturated) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("Result %0d differs: expected %0d/%b/%b, got %0d/%b/%b",
                                     o_checked, want.velocity_cm_s, want.zero_interval,
                                     want.saturated, i_out_item.velocity_cm_s,
                                     i_out_item.zero_interval, i_out_item.saturated);
                        end
                    end
                end
            end

            // Each accepted item yields exactly one result.
            if (i_in_valid && i_in_ready) begin
                want = advance_velocity(i_in_item);
                pending_velocities.push_back(want);
                if (want.zero_interval) begin
                    o_zero_count++;
                end
                if (want.saturated) begin
                    o_clip_count++;
                end
            end
            o_pending = pending_velocities.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_altitude_rate_ema_estimator_top.sv
`default_nettype none

module tb_altitude_rate_ema_estimator_top;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 116;
    localparam int IDLE_LIMIT    = 4000;
    localparam int TAIL_CYCLES   = 2 * (are_pkg::FRAC_BITS_DEF + 41);

    // Receiver stall patterns.
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    are_pkg::t_in_item           in_item   = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    are_pkg::t_out_item          out_item;
    logic                        cfg_we    = 1'b0;
    logic [are_pkg::ALPHA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int checked;
    int zero_count;
    int clip_count;

    int          items_sent  = 0;
    int          cfg_writes  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          ready_mode  = RX_ALWAYS;
    int          ready_span  = 0;
    int          ready_tick  = 0;
    int          climb       = 0;
    logic [31:0] traj_alt;
    logic [31:0] traj_time;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    altitude_rate_ema_estimator_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    altitude_rate_ema_estimator_checker velocity_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_zero_count (zero_count),
        .o_clip_count (clip_count)
    );

    // The receiver switches at random between stall patterns.
    always @(negedge clk) begin
        if (ready_span == 0) begin
            ready_mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
            ready_span = $urandom_range(20, 300);
        end else begin
            ready_span--;
        end
        ready_tick++;
        case (ready_mode)
            RX_ALWAYS:   out_ready <= 1'b1;
            RX_COIN:     out_ready <= $urandom_range(0, 1);
            RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            default:     out_ready <= (ready_tick % 7 >= 3);
        endcase
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("** altitude_rate_ema_estimator_top: FAILED **");
                $finish;
            end
        end
    end

    // Offers one sample; bursts of random length are separated by random gaps.
    task automatic send_sample(input logic [31:0] alt, input logic [31:0] stamp);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(10, 90);
            end else begin
                gap = $urandom_range(1, 4);
            end
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_item.altitude_cm = alt;
        in_item.time_us     = stamp;
        in_valid            = 1'b1;
        burst_left--;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted velocity has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Changes the smoothing factor once the block has nothing in flight.
    task automatic set_smoothing(input logic [are_pkg::ALPHA_W-1:0] value);
        drain_results();
        cfg_data = value;
        cfg_we   = 1'b1;
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_writes++;
    endtask

    // Mostly steady flight with random climb, mixed with jumps and pure noise.
    task automatic send_random_sample();
        int pick;
        int step;
        int drift;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            case ($urandom_range(0, 19))
                0:       step = 0;
                1:       step = $urandom_range(1, 40);
                default: step = $urandom_range(1000, 20000);
            endcase
            if ($urandom_range(0, 29) == 0) begin
                climb = $signed($urandom_range(0, 20000)) - 10000;
            end
            // Signed climb over the step plus a little sensor noise.
            drift     = climb * step / 1000000 + ($signed($urandom_range(0, 60)) - 30);
            traj_time = traj_time + step;
            traj_alt  = traj_alt + 32'(drift);
        end else if (pick < 86) begin
            // A large jump over a few microseconds clips the rate.
            traj_time = traj_time + $urandom_range(1, 8);
            traj_alt  = $urandom;
        end else begin
            traj_time = $urandom;
            traj_alt  = $urandom;
        end
        send_sample(traj_alt, traj_time);
    endtask

    initial begin
        logic [are_pkg::ALPHA_W-1:0] gain;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Reset factor: first sample against time zero, repeated stamps, the
        // altitude extremes over one microsecond, and a timestamp wrap.
        send_sample(32'd0, 32'd0);
        send_sample(32'd100, 32'd10000);
        send_sample(32'd100, 32'd10000);
        send_sample(32'h7FFF_FFFF, 32'd10001);
        send_sample(32'h8000_0000, 32'd10002);
        send_sample(-32'sd50, 32'hFFFF_FF00);
        send_sample(-32'sd40, 32'h0000_0100);
        send_sample(32'd0, 32'hFFFF_FFFF);

        // Unity factor shows the rate itself: one step just past the positive
        // limit, one exactly at the negative limit, then slow descents.
        set_smoothing(are_pkg::ALPHA_ONE);
        send_sample(32'd0, 32'h0001_0000);
        send_sample(32'd33554432, 32'h0001_0000 + 32'd15625);
        send_sample(32'd0, 32'h0001_0000 + 32'd31250);
        send_sample(-32'sd1, 32'h0001_0000 + 32'd1031250);
        send_sample(-32'sd2, 32'h0001_0000 + 32'd1031257);

        // A factor above one must act as one.
        set_smoothing('1);
        send_sample(32'd500, 32'h2000_0000);
        send_sample(32'd700, 32'h2000_0003);
        send_sample(32'd700, 32'h2000_0003);

        // A zero factor holds the velocity even when the rate clips.
        set_smoothing('0);
        send_sample(32'd1000000, 32'h3000_0000);
        send_sample(32'h8000_0000, 32'h3000_0001);
        send_sample(32'h7FFF_FFFF, 32'h3000_0002);

        traj_time = $urandom;
        traj_alt  = $urandom_range(0, 100000);

        // Random phases, each under its own smoothing factor.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       gain = are_pkg::ALPHA_ONE;
                1:       gain = '0;
                2:       gain = '1;
                3:       gain = are_pkg::ALPHA_ONE + 17'd1;
                4:       gain = 17'd1;
                5:       gain = are_pkg::ALPHA_RESET;
                6:       gain = $urandom_range(2, 65535);
                default: gain = $urandom_range(0, 131071);
            endcase
            set_smoothing(gain);
            repeat (PHASE_ITEMS) send_random_sample();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d samples under %0d smoothing factors, zero through above one.",
                 items_sent, cfg_writes + 1);
        $display("Checked %0d velocities: %0d held on a zero interval, %0d with a clipped rate.",
                 checked, zero_count, clip_count);
        if (pending != 0) begin
            $display("%0d predicted velocities never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("** altitude_rate_ema_estimator_top: PASSED **");
        end else begin
            $display("** altitude_rate_ema_estimator_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
